// ===== rtl/core/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the split-step phase rotator: payload
// structs, mode and register codes, CORDIC widths and the arctangent table.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Mode codes carried with each input item
  localparam logic [1:0] MODE_LINEAR    = 2'd0;
  localparam logic [1:0] MODE_NONLINEAR = 2'd1;
  localparam logic [1:0] MODE_NORMALIZE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LOG2_SIZE = 1'b1;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values
  localparam logic [23:0] STEP_SIZE_RST      = 24'd16777;
  localparam logic [4:0]  GRID_LOG2_SIZE_RST = 5'd12;

  // Datapath widths
  localparam int unsigned GUARD_BITS = 14;  // extra fraction bits in CORDIC
  localparam int unsigned XW         = 48;  // CORDIC x/y width
  localparam int unsigned ZW         = 34;  // CORDIC residual angle width

  // radians to turns at 2^-32, and 1/K in Q0.30
  localparam logic [29:0] TURN_SCALE = 30'd683565276;
  localparam logic [29:0] GAIN_Q30   = 30'd652032874;

  // atan(2^-i) in turns, scale 2^-32
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Input item
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] sample_re;
    logic signed [31:0] sample_im;
    logic [23:0]        wave_number_sq;
  } ssp_in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
  } ssp_out_t;

  // Data moving along the CORDIC chain; rot low means x/y pass untouched
  typedef struct packed {
    logic               rot;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } ssp_cordic_t;

endpackage

// ===== rtl/core/ssp_phase_front.sv =====
// ----------------------------------------------------------------------------
// ssp_phase_front
// Eight-stage front end: forms the phase for linear or nonlinear mode,
// converts it to turns, folds it into the right half plane and scales the
// sample for the CORDIC chain. Normalize and pass-through results are
// formed here and ride the chain unrotated.
// ----------------------------------------------------------------------------
module ssp_phase_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ssp_pkg::ssp_in_t     data_i,
  input  logic [23:0]          step_size_i,
  input  logic [4:0]           grid_log2_size_i,
  output logic                 valid_o,
  output ssp_pkg::ssp_cordic_t data_o
);
  import ssp_pkg::*;

  // stage valids
  logic [7:1] v_q;

  // stage 1: magnitudes squared and linear product
  logic [1:0]         s1_mode_q;
  logic signed [31:0] s1_re_q, s1_im_q;
  logic [62:0]        s1_sqre_q, s1_sqim_q;
  logic [47:0]        s1_lin_q;
  logic [31:0]        mr, mi;

  // stage 2: intensity p, saturated
  logic [1:0]         s2_mode_q;
  logic signed [31:0] s2_re_q, s2_im_q;
  logic [47:0]        s2_lin_q;
  logic [30:0]        s2_p_q;
  logic [63:0]        psum;
  logic [51:0]        pshr;

  // stage 3: p squared
  logic [1:0]         s3_mode_q;
  logic signed [31:0] s3_re_q, s3_im_q;
  logic [47:0]        s3_lin_q;
  logic [30:0]        s3_p_q;
  logic [61:0]        s3_pp_q;

  // stage 4: g = p - p*p
  logic [1:0]         s4_mode_q;
  logic signed [31:0] s4_re_q, s4_im_q;
  logic [47:0]        s4_lin_q;
  logic [37:0]        s4_g_q;
  logic               s4_neg_q;
  logic [37:0]        q_w, p_w;
  logic               neg_w;

  // stage 5: g * step
  logic [1:0]         s5_mode_q;
  logic signed [31:0] s5_re_q, s5_im_q;
  logic [47:0]        s5_lin_q;
  logic [61:0]        s5_nl_q;
  logic               s5_neg_q;

  // stage 6: phase magnitude times turn scale, two partial products
  logic [1:0]         s6_mode_q;
  logic signed [31:0] s6_re_q, s6_im_q;
  logic [52:0]        s6_pl_q, s6_ph_q;
  logic               s6_neg_q;
  logic [45:0]        mag_w;

  // stage 7: partial products summed
  logic [1:0]         s7_mode_q;
  logic signed [31:0] s7_re_q, s7_im_q;
  logic [63:0]        s7_prod_q;
  logic               s7_neg_q;

  // stage 8 logic
  logic [63:0]          phit;
  logic [31:0]          t_w;
  logic                 fold;
  logic signed [XW-1:0] x_sc, y_sc;
  logic signed [31:0]   nr, ni;
  ssp_cordic_t          c_d;
  ssp_cordic_t          c_q;
  logic                 c_valid_q;

  function automatic logic [31:0] s1_in_abs(input logic signed [31:0] v);
    s1_in_abs = v[31] ? (~v + 32'd1) : v;
  endfunction

  assign mr = s1_in_abs(data_i.sample_re);
  assign mi = s1_in_abs(data_i.sample_im);

  assign psum = {1'b0, s1_sqre_q} + {1'b0, s1_sqim_q};
  assign pshr = psum[63:12];

  assign q_w   = s3_pp_q[61:24];
  assign p_w   = {7'd0, s3_p_q};
  assign neg_w = q_w > p_w;

  // linear phase is k2*dt/2, always negative; nonlinear keeps the sign of g
  assign mag_w = (s5_mode_q == MODE_LINEAR) ? {11'd0, s5_lin_q[47:13]} : s5_nl_q[61:16];

  // phase in turns, then fold the left half plane by a half turn
  assign phit = s7_neg_q ? (~s7_prod_q + 64'd1) : s7_prod_q;
  assign t_w  = phit[63:32];
  assign fold = t_w[31] ^ t_w[30];
  assign x_sc = XW'($signed({s7_re_q, {GUARD_BITS{1'b0}}}));
  assign y_sc = XW'($signed({s7_im_q, {GUARD_BITS{1'b0}}}));
  assign nr   = s7_re_q >>> grid_log2_size_i;
  assign ni   = s7_im_q >>> grid_log2_size_i;

  always_comb begin
    c_d.rot = (s7_mode_q == MODE_LINEAR) || (s7_mode_q == MODE_NONLINEAR);
    c_d.z   = ZW'($signed({t_w[31] ^ fold, t_w[30:0]}));
    if (c_d.rot) begin
      c_d.x = fold ? -x_sc : x_sc;
      c_d.y = fold ? -y_sc : y_sc;
    end else if (s7_mode_q == MODE_NORMALIZE) begin
      c_d.x = XW'(nr);
      c_d.y = XW'(ni);
    end else begin
      c_d.x = XW'(s7_re_q);
      c_d.y = XW'(s7_im_q);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      v_q       <= {v_q[6:1], valid_i};
      c_valid_q <= v_q[7];
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mode_q <= data_i.mode;
      s1_re_q   <= data_i.sample_re;
      s1_im_q   <= data_i.sample_im;
      s1_sqre_q <= 63'(mr * mr);
      s1_sqim_q <= 63'(mi * mi);
      s1_lin_q  <= 48'(data_i.wave_number_sq) * 48'(step_size_i);

      s2_mode_q <= s1_mode_q;
      s2_re_q   <= s1_re_q;
      s2_im_q   <= s1_im_q;
      s2_lin_q  <= s1_lin_q;
      s2_p_q    <= (pshr[51:31] != '0) ? 31'h7FFF_FFFF : pshr[30:0];

      s3_mode_q <= s2_mode_q;
      s3_re_q   <= s2_re_q;
      s3_im_q   <= s2_im_q;
      s3_lin_q  <= s2_lin_q;
      s3_p_q    <= s2_p_q;
      s3_pp_q   <= 62'(s2_p_q) * 62'(s2_p_q);

      s4_mode_q <= s3_mode_q;
      s4_re_q   <= s3_re_q;
      s4_im_q   <= s3_im_q;
      s4_lin_q  <= s3_lin_q;
      s4_neg_q  <= neg_w;
      s4_g_q    <= neg_w ? (q_w - p_w) : (p_w - q_w);

      s5_mode_q <= s4_mode_q;
      s5_re_q   <= s4_re_q;
      s5_im_q   <= s4_im_q;
      s5_lin_q  <= s4_lin_q;
      s5_neg_q  <= s4_neg_q;
      s5_nl_q   <= 62'(s4_g_q) * 62'(step_size_i);

      s6_mode_q <= s5_mode_q;
      s6_re_q   <= s5_re_q;
      s6_im_q   <= s5_im_q;
      s6_neg_q  <= (s5_mode_q == MODE_LINEAR) ? 1'b1 : s5_neg_q;
      s6_pl_q   <= 53'(mag_w[22:0]) * 53'(TURN_SCALE);
      s6_ph_q   <= 53'(mag_w[45:23]) * 53'(TURN_SCALE);

      s7_mode_q <= s6_mode_q;
      s7_re_q   <= s6_re_q;
      s7_im_q   <= s6_im_q;
      s7_neg_q  <= s6_neg_q;
      s7_prod_q <= {s6_ph_q[40:0], 23'd0} + {11'd0, s6_pl_q};

      c_q       <= c_d;
    end
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_q;

endmodule

// ===== rtl/core/ssp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ssp_cordic_cell
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE) in the
// direction that drives the residual angle toward zero, then a register.
// ----------------------------------------------------------------------------
module ssp_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ssp_pkg::ssp_cordic_t data_i,
  output logic                 valid_o,
  output ssp_pkg::ssp_cordic_t data_o
);
  import ssp_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'(ATAN_TURNS[STAGE]);

  logic signed [XW-1:0] xs, ys;
  ssp_cordic_t          d;
  ssp_cordic_t          data_q;
  logic                 valid_q;

  assign xs = data_i.x >>> STAGE;
  assign ys = data_i.y >>> STAGE;

  // rotate toward zero residual; bypass items pass unchanged
  always_comb begin
    d = data_i;
    if (data_i.rot) begin
      if (!data_i.z[ZW-1]) begin
        d.x = data_i.x - ys;
        d.y = data_i.y + xs;
        d.z = data_i.z - Atan;
      end else begin
        d.x = data_i.x + ys;
        d.y = data_i.y - xs;
        d.z = data_i.z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/ssp_gain_out.sv =====
// ----------------------------------------------------------------------------
// ssp_gain_out
// CORDIC gain correction with round half away from zero and saturation to
// 32 bits, four stages ending in the output register.
// ----------------------------------------------------------------------------
module ssp_gain_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ssp_pkg::ssp_cordic_t data_i,
  output logic                 valid_o,
  output ssp_pkg::ssp_out_t    data_o
);
  import ssp_pkg::*;

  logic [4:1] v_q;

  // stage 1: magnitudes
  logic          g1_rot_q;
  logic [31:0]   g1_bre_q, g1_bim_q;
  logic [XW-1:0] g1_mre_q, g1_mim_q;
  logic          g1_nre_q, g1_nim_q;

  // stage 2: partial products
  logic          g2_rot_q;
  logic [31:0]   g2_bre_q, g2_bim_q;
  logic          g2_nre_q, g2_nim_q;
  logic [61:0]   g2_hre_q, g2_him_q;
  logic [45:0]   g2_lre_q, g2_lim_q;

  // stage 3: rounded magnitudes
  logic          g3_rot_q;
  logic [31:0]   g3_bre_q, g3_bim_q;
  logic          g3_nre_q, g3_nim_q;
  logic [34:0]   g3_rre_q, g3_rim_q;
  logic [62:0]   tre, tim;

  // stage 4: output register
  ssp_out_t      out_q;

  function automatic logic [XW-1:0] mag_of(input logic signed [XW-1:0] v);
    mag_of = v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  // apply sign and clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat_of(input logic [34:0] r, input logic neg);
    if (neg) begin
      sat_of = (r > 35'h0_8000_0000) ? 32'sh8000_0000 : 32'(~r + 35'd1);
    end else begin
      sat_of = (r > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : r[31:0];
    end
  endfunction

  assign tre = {1'b0, g2_hre_q} + 63'd134217728 + 63'(g2_lre_q[45:16]);
  assign tim = {1'b0, g2_him_q} + 63'd134217728 + 63'(g2_lim_q[45:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_rot_q <= data_i.rot;
      g1_bre_q <= data_i.x[31:0];
      g1_bim_q <= data_i.y[31:0];
      g1_mre_q <= mag_of(data_i.x);
      g1_mim_q <= mag_of(data_i.y);
      g1_nre_q <= data_i.x[XW-1];
      g1_nim_q <= data_i.y[XW-1];

      g2_rot_q <= g1_rot_q;
      g2_bre_q <= g1_bre_q;
      g2_bim_q <= g1_bim_q;
      g2_nre_q <= g1_nre_q;
      g2_nim_q <= g1_nim_q;
      g2_hre_q <= 62'(g1_mre_q[XW-1:16]) * 62'(GAIN_Q30);
      g2_him_q <= 62'(g1_mim_q[XW-1:16]) * 62'(GAIN_Q30);
      g2_lre_q <= 46'(g1_mre_q[15:0]) * 46'(GAIN_Q30);
      g2_lim_q <= 46'(g1_mim_q[15:0]) * 46'(GAIN_Q30);

      g3_rot_q <= g2_rot_q;
      g3_bre_q <= g2_bre_q;
      g3_bim_q <= g2_bim_q;
      g3_nre_q <= g2_nre_q;
      g3_nim_q <= g2_nim_q;
      g3_rre_q <= tre[62:28];
      g3_rim_q <= tim[62:28];

      if (g3_rot_q) begin
        out_q.out_re <= sat_of(g3_rre_q, g3_nre_q);
        out_q.out_im <= sat_of(g3_rim_q, g3_nim_q);
      end else begin
        out_q.out_re <= g3_bre_q;
        out_q.out_im <= g3_bim_q;
      end
    end
  end

  assign valid_o = v_q[4];
  assign data_o  = out_q;

endmodule

// ===== rtl/core/split_step_phase_rotator_unit.sv =====
// ----------------------------------------------------------------------------
// split_step_phase_rotator_unit
// Split-step phase rotation of complex grid samples: linear (dispersion)
// rotation, nonlinear rotation by intensity, or normalize shift.
// ----------------------------------------------------------------------------
// Pipeline: 8 phase stages, one per CORDIC cell (default of 20 stages), 4 gain,
//   from input transfer to result.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset: clears all valid bits; step_size and grid_log2_size return to
//   16777 and 12. No clearing pass.
// ----------------------------------------------------------------------------
module split_step_phase_rotator_unit #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ssp_pkg::ssp_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ssp_pkg::ssp_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ssp_pkg::*;

  logic        en;
  logic [23:0] step_size_q;
  logic [4:0]  grid_log2_size_q;

  logic        cell_valid [CORDIC_STAGES+1];
  ssp_cordic_t cell_data  [CORDIC_STAGES+1];

  // pipe advances unless a finished result is held back
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q      <= STEP_SIZE_RST;
      grid_log2_size_q <= GRID_LOG2_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_SIZE:      step_size_q      <= cfg_data_i[23:0];
        CFG_GRID_LOG2_SIZE: grid_log2_size_q <= cfg_data_i[4:0];
        default:            ;
      endcase
    end
  end

  // phase formation
  ssp_phase_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (in_valid_i),
    .data_i           (in_data_i),
    .step_size_i      (step_size_q),
    .grid_log2_size_i (grid_log2_size_q),
    .valid_o          (cell_valid[0]),
    .data_o           (cell_data[0])
  );

  // CORDIC chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ssp_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[i]),
      .data_i  (cell_data[i]),
      .valid_o (cell_valid[i+1]),
      .data_o  (cell_data[i+1])
    );
  end

  // gain correction and output register
  ssp_gain_out u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cell_valid[CORDIC_STAGES]),
    .data_i  (cell_data[CORDIC_STAGES]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // folded angle entering the chain lies within a quarter turn
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[0] && cell_data[0].rot) |->
      (cell_data[0].z >= -34'sd1073741824 && cell_data[0].z < 34'sd1073741824))
    else $error("CORDIC input angle outside a quarter turn");

  // a held result freezes the chain entry
  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(cell_data[0]) && $stable(cell_valid[0]))
    else $error("chain moved while output held");

  // a new result appears only after the pipe advanced
  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(en))
    else $error("result appeared without pipe advance");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for split_step_phase_rotator_unit. A behavioral
// predictor works out the rotated, normalized or passed-through sample for
// every input transfer; a monitor compares each output transfer field by
// field, in order. Both sides idle and stall at random in bursts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssp_pkg::*;

  localparam int unsigned CORDIC_STAGES  = 20;
  localparam int unsigned PIPE_LATENCY   = 12 + CORDIC_STAGES;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam logic [1:0]  MODE_UNUSED    = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  ssp_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  ssp_out_t              out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // bench copy of the registers
  bit [23:0] cfg_step  = STEP_SIZE_RST;
  bit [4:0]  cfg_shift = GRID_LOG2_SIZE_RST;

  ssp_out_t    expected_samples[$];
  int unsigned mode_counts[4];
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned reg_writes;
  int unsigned quiet_cycles;
  bit          gaps_on = 1'b1;

  split_step_phase_rotator_unit #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // scale by 1/K with round half away from zero, then clamp to 32 bits
  function automatic logic [31:0] gain_round_sat(input longint v);
    bit [63:0] mag;
    bit [63:0] acc;
    longint    r;
    mag = (v < 0) ? -v : v;
    acc = (mag >> 16) * 64'(GAIN_Q30) + (64'd1 << 27)
        + (((mag & 64'hFFFF) * 64'(GAIN_Q30)) >> 16);
    r = longint'(acc >> 28);
    if (v < 0) r = -r;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    else if (r < -64'sd2147483648) r = -64'sd2147483648;
    return 32'(r);
  endfunction

  // rotate by phi (radians, 2^-32) through the turn-domain CORDIC
  function automatic ssp_out_t cordic_rotate(input longint re, input longint im,
                                             input bit [63:0] phi);
    bit [63:0] prod;
    bit [31:0] turns;
    longint    x, y, z, xs, ys;
    ssp_out_t  res;
    prod  = phi * 64'(TURN_SCALE);
    turns = prod[63:32];
    x = re <<< GUARD_BITS;
    y = im <<< GUARD_BITS;
    // fold the back half-plane onto the front one
    if (turns >= 32'h4000_0000 && turns < 32'hC000_0000) begin
      x = -x;
      y = -y;
      turns = turns - 32'h8000_0000;
    end
    z = longint'($signed(turns));
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'({32'b0, ATAN_TURNS[i]});
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'({32'b0, ATAN_TURNS[i]});
      end
    end
    res.out_re = gain_round_sat(x);
    res.out_im = gain_round_sat(y);
    return res;
  endfunction

  function automatic ssp_out_t phase_rotate_predict(input ssp_in_t item);
    longint    re, im;
    bit [63:0] k2, step, mag, mr, mi, pw, sq, g;
    bit        neg;
    ssp_out_t  res;
    re   = {{32{item.sample_re[31]}}, item.sample_re};
    im   = {{32{item.sample_im[31]}}, item.sample_im};
    k2   = 64'(item.wave_number_sq);
    step = 64'(cfg_step);
    res.out_re = item.sample_re;
    res.out_im = item.sample_im;
    case (item.mode)
      MODE_LINEAR: begin
        mag = (k2 * step) >> 13;
        res = cordic_rotate(re, im, 64'd0 - mag);
      end
      MODE_NONLINEAR: begin
        mr = (re < 0) ? -re : re;
        mi = (im < 0) ? -im : im;
        pw = (mr * mr + mi * mi) >> 12;
        if (pw > 64'h7FFF_FFFF) pw = 64'h7FFF_FFFF;
        sq  = (pw * pw) >> 24;
        neg = sq > pw;
        g   = neg ? sq - pw : pw - sq;
        mag = (g * step) >> 16;
        res = cordic_rotate(re, im, neg ? 64'd0 - mag : mag);
      end
      MODE_NORMALIZE: begin
        res.out_re = 32'(re >>> cfg_shift);
        res.out_im = 32'(im >>> cfg_shift);
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic ssp_in_t make_item(input logic [1:0] mode, input logic [31:0] re,
                                        input logic [31:0] im, input logic [23:0] k2);
    ssp_in_t item;
    item.mode           = mode;
    item.sample_re      = re;
    item.sample_im      = im;
    item.wave_number_sq = k2;
    return item;
  endfunction

  function automatic logic [31:0] rand_sample();
    logic [31:0] raw;
    logic [31:0] value;
    raw = $urandom();
    case ($urandom_range(0, 6))
      0, 1: value = raw;
      2, 3, 4: value = $signed(raw) >>> $urandom_range(10, 16);  // near unit magnitude
      5: value = $signed(raw) >>> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 4))
          0: value = 32'h7FFF_FFFF;
          1: value = 32'h8000_0000;
          2: value = 32'h0000_0000;
          3: value = 32'h0000_0001;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return value;
  endfunction

  function automatic ssp_in_t rand_item();
    logic [1:0]  mode;
    logic [23:0] k2;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) mode = MODE_LINEAR;
    else if (pick < 12) mode = MODE_NONLINEAR;
    else if (pick < 18) mode = MODE_NORMALIZE;
    else mode = MODE_UNUSED;
    k2 = 24'($urandom());
    if ($urandom_range(0, 1) == 0) k2 = k2 >> $urandom_range(0, 23);
    return make_item(mode, rand_sample(), rand_sample(), k2);
  endfunction

  // one input transfer, with an optional idle burst in front of it
  task automatic send_sample(input ssp_in_t item);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_samples.push_back(phase_rotate_predict(item));
    mode_counts[item.mode]++;
  endtask

  // hold off the sender until every expected result has been seen
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_samples.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    wait_results_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_STEP_SIZE:      cfg_step  = value;
      CFG_GRID_LOG2_SIZE: cfg_shift = value[4:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return STEP_SIZE_RST;
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  // low five bits carry the shift; upper data bits are junk the block drops
  function automatic logic [CFG_DATA_W-1:0] rand_shift();
    logic [CFG_DATA_W-1:0] value;
    value = '0;
    if ($urandom_range(0, 3) == 0) value = CFG_DATA_W'($urandom());
    value[4:0] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                             : 5'($urandom_range(0, 16));
    return value;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // field extremes, each mode, and the named corner cases
  task automatic test_directed_cases();
    // reset register values
    send_sample(make_item(MODE_LINEAR, 32'h7FFF_FFFF, 32'h0, 24'h0));
    send_sample(make_item(MODE_LINEAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF));
    send_sample(make_item(MODE_LINEAR, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF));
    send_sample(make_item(MODE_LINEAR, 32'h0004_0000, 32'hFFFC_0000, 24'h10_0000));
    // large intensity: p clamps before squaring
    send_sample(make_item(MODE_NONLINEAR, 32'h8000_0000, 32'h8000_0000, 24'h0));
    send_sample(make_item(MODE_NONLINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF));
    // unit intensity gives zero phase
    send_sample(make_item(MODE_NONLINEAR, 32'h0004_0000, 32'h0, 24'h0));
    send_sample(make_item(MODE_NONLINEAR, 32'h0, 32'h0, 24'h0));
    send_sample(make_item(MODE_NONLINEAR, 32'h0002_0000, 32'hFFFE_0000, 24'h0));
    send_sample(make_item(MODE_NONLINEAR, 32'h0008_0000, 32'h0006_0000, 24'h0));
    send_sample(make_item(MODE_NORMALIZE, 32'h8000_0000, 32'h7FFF_FFFF, 24'h0));
    send_sample(make_item(MODE_NORMALIZE, 32'hFFFF_FFFF, 32'h0000_0001, 24'hFF_FFFF));
    // unused mode passes the sample through
    send_sample(make_item(MODE_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF));
    send_sample(make_item(MODE_UNUSED, 32'h1234_5678, 32'hEDCB_A987, 24'h0));
    // largest step: k2 chosen for about -45 degrees drives both parts past full scale
    write_reg(CFG_STEP_SIZE, '1);
    send_sample(make_item(MODE_LINEAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1647099));
    send_sample(make_item(MODE_LINEAR, 32'h8000_0000, 32'h8000_0000, 24'd1647099));
    send_sample(make_item(MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1647099));
    send_sample(make_item(MODE_NONLINEAR, 32'h0005_A827, 32'h0, 24'h0));
    // shifts beyond the grid range still apply
    write_reg(CFG_GRID_LOG2_SIZE, 24'd31);
    send_sample(make_item(MODE_NORMALIZE, 32'h8000_0000, 32'h7FFF_FFFF, 24'h0));
    send_sample(make_item(MODE_NORMALIZE, 32'h4000_0000, 32'hC000_0000, 24'h0));
  endtask

  // batches of random traffic at fixed register settings, extremes included
  task automatic test_register_sweep();
    logic [CFG_DATA_W-1:0] steps[5];
    logic [CFG_DATA_W-1:0] shifts[5];
    steps  = '{24'd0, 24'hFF_FFFF, 24'hFF_FFFF, rand_step(), STEP_SIZE_RST};
    shifts = '{24'd0, 24'd16, 24'hFF_FFFF, rand_shift(), 24'(GRID_LOG2_SIZE_RST)};
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_STEP_SIZE, steps[s]);
      write_reg(CFG_GRID_LOG2_SIZE, shifts[s]);
      repeat (40) send_sample(rand_item());
    end
  endtask

  // main random run; idling is on in two phases of every three and off in the third
  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on = (ph % 3 != 2);
      write_reg(CFG_STEP_SIZE, rand_step());
      write_reg(CFG_GRID_LOG2_SIZE, rand_shift());
      for (int n = 0; n < 120; n++) begin
        if (ph == 1 && n == 60) wait_results_drained();
        send_sample(rand_item());
      end
    end
  endtask

  // closing stretch at full rate, no idling anywhere
  task automatic test_steady_tail();
    gaps_on = 1'b0;
    write_reg(CFG_STEP_SIZE, rand_step());
    write_reg(CFG_GRID_LOG2_SIZE, rand_shift());
    repeat (80) send_sample(rand_item());
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall bursts and result checking
  // --------------------------------------------------------------------------

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    if (mismatch_count < 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin : check_results
    ssp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, out_data_o.out_re);
      end else begin
        want = expected_samples.pop_front();
        if (out_data_o.out_re !== want.out_re)
          report_mismatch("out_re", want.out_re, out_data_o.out_re);
        if (out_data_o.out_im !== want.out_im)
          report_mismatch("out_im", want.out_im, out_data_o.out_im);
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_register_sweep();
    test_random_traffic();
    test_steady_tail();

    wait_results_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);

    $display("covered %0d linear, %0d nonlinear, %0d normalize, %0d unused-mode samples",
             mode_counts[MODE_LINEAR], mode_counts[MODE_NONLINEAR],
             mode_counts[MODE_NORMALIZE], mode_counts[MODE_UNUSED]);
    $display("%0d results checked over %0d register writes, %0d mismatches",
             results_checked, reg_writes, mismatch_count);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ssp_pkg.sv
rtl/core/ssp_phase_front.sv
rtl/core/ssp_cordic_cell.sv
rtl/core/ssp_gain_out.sv
rtl/core/split_step_phase_rotator_unit.sv
bench/testbench.sv
